[hdl/mssd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mssd_pkg;

	localparam int VALUE_W   = 16;
	localparam int DWELL_W   = 16;
	localparam int POS_N     = 4;
	localparam int SEG_W     = 8;
	localparam int QDEPTH_DEF = 2;

	localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd50;
	localparam logic [DWELL_W-1:0] OFF_THREE   = 16'd30;
	localparam logic [DWELL_W-1:0] OFF_FOUR_LO = 16'd20;
	localparam logic [DWELL_W-1:0] OFF_FOUR_HI = 16'd30;
	localparam logic [DWELL_W-1:0] OFF_FOUR_TOP = 16'd60;

	// digit count minus one
	localparam logic [1:0] CNT_ONE   = 2'd0;
	localparam logic [1:0] CNT_TWO   = 2'd1;
	localparam logic [1:0] CNT_THREE = 2'd2;
	localparam logic [1:0] CNT_FOUR  = 2'd3;

	// floor(x/10) = (x * RECIP10) >> RECIP_SH, exact for 16-bit x
	localparam logic [15:0] RECIP10  = 16'd52429;
	localparam int          RECIP_SH = 19;

	localparam int CFG_AW = 3;
	localparam logic REG_DWELL_BASE = 1'b0;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [1:0]         cnt_m1;
	} item_t;

	function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 8'hF7;
			4'd1: s = 8'h34;
			4'd2: s = 8'h7B;
			4'd3: s = 8'h7E;
			4'd4: s = 8'hBC;
			4'd5: s = 8'hDE;
			4'd6: s = 8'hDF;
			4'd7: s = 8'h74;
			4'd8: s = 8'hFF;
			default: s = 8'hFC;
		endcase
		return s;
	endfunction

	function automatic logic [DWELL_W-1:0] sat_sub(input logic [DWELL_W-1:0] a,
			input logic [DWELL_W-1:0] b);
		return (a > b) ? (a - b) : '0;
	endfunction

endpackage

`default_nettype wire

[hdl/mssd_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module mssd_front import mssd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [VALUE_W-1:0] value,
	output logic                    push_valid,
	input  wire logic               push_ready,
	output item_t                   push_item
);

	logic  valid_s1;
	item_t item_s1;
	logic [1:0] cnt_m1;

	// digit count from magnitude
	always_comb begin
		if (value < 16'd10) begin
			cnt_m1 = CNT_ONE;
		end else if (value < 16'd100) begin
			cnt_m1 = CNT_TWO;
		end else if (value < 16'd1000) begin
			cnt_m1 = CNT_THREE;
		end else begin
			cnt_m1 = CNT_FOUR;
		end
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.value  <= value;
			item_s1.cnt_m1 <= cnt_m1;
		end
	end

endmodule

`default_nettype wire

[hdl/mssd_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module mssd_fifo import mssd_pkg::*; #(
	parameter int DEPTH = QDEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr_valid,
	output logic       wr_ready,
	input  wire item_t wr_item,
	output logic       rd_valid,
	input  wire logic  rd_ready,
	output item_t      rd_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	item_t         slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign wr_ready = (cnt_q != CNT_FULL);
	assign rd_valid = (cnt_q != '0);
	assign rd_item  = slot_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

`default_nettype wire

[hdl/mssd_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module mssd_back import mssd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [DWELL_W-1:0] dwell_base,
	input  wire logic               pop_valid,
	output logic                    pop_ready,
	input  wire item_t              pop_item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [POS_N-1:0]        digit_enable,
	output logic [SEG_W-1:0]        segments_lit,
	output logic [DWELL_W-1:0]      dwell_ticks,
	output logic                    hold,
	output logic                    last
);

	logic               busy_q;
	logic [VALUE_W-1:0] w_q;
	logic [1:0]         k_q;
	logic [1:0]         cnt_q;

	logic               ov_q;
	logic [POS_N-1:0]   en_q;
	logic [SEG_W-1:0]   seg_q;
	logic [DWELL_W-1:0] dwell_q;
	logic               hold_q, last_q;

	logic               src_valid, advance, is_last;
	logic [VALUE_W-1:0] src_w;
	logic [1:0]         src_k, src_cnt;
	logic [31:0]        prod;
	logic [VALUE_W-1:0] quo;
	logic [VALUE_W-1:0] rem_full;
	logic [3:0]         digit;
	logic [DWELL_W-1:0] dwell;

	// current item: the one in progress, else the queue head
	assign src_valid = busy_q || pop_valid;
	assign src_w     = busy_q ? w_q   : pop_item.value;
	assign src_k     = busy_q ? k_q   : 2'd0;
	assign src_cnt   = busy_q ? cnt_q : pop_item.cnt_m1;
	assign advance   = src_valid && (!ov_q || out_ready);
	assign pop_ready = !busy_q && (!ov_q || out_ready);
	assign is_last   = (src_k == src_cnt);

	// one divide by ten per result
	assign prod     = 32'(src_w) * 32'(RECIP10);
	assign quo      = VALUE_W'(prod >> RECIP_SH);
	assign rem_full = src_w - {quo[VALUE_W-4:0], 3'b000} - {quo[VALUE_W-2:0], 1'b0};

	always_comb begin
		if (src_k == 2'd3) begin
			// thousands quotient may exceed 9
			digit = (src_w >= 16'd9) ? 4'd9 : src_w[3:0];
		end else begin
			digit = rem_full[3:0];
		end
	end

	always_comb begin
		case (src_cnt)
			CNT_ONE:   dwell = '0;
			CNT_TWO:   dwell = dwell_base;
			CNT_THREE: dwell = sat_sub(dwell_base, OFF_THREE);
			default: begin
				if (src_k[1] == 1'b0) begin
					dwell = sat_sub(dwell_base, OFF_FOUR_LO);
				end else if (src_k[0] == 1'b0) begin
					dwell = sat_sub(dwell_base, OFF_FOUR_HI);
				end else begin
					dwell = sat_sub(dwell_base, OFF_FOUR_TOP);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (advance) begin
				busy_q <= !is_last;
			end
			if (advance) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			w_q     <= quo;
			k_q     <= src_k + 2'd1;
			cnt_q   <= src_cnt;
			en_q    <= POS_N'(1) << src_k;
			seg_q   <= seg_of(digit);
			dwell_q <= dwell;
			hold_q  <= (src_cnt == CNT_ONE);
			last_q  <= is_last;
		end
	end

	assign out_valid    = ov_q;
	assign digit_enable = en_q;
	assign segments_lit = seg_q;
	assign dwell_ticks  = dwell_q;
	assign hold         = hold_q;
	assign last         = last_q;

endmodule

`default_nettype wire

[hdl/multiplexed_seven_segment_driver.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake            payload
// -------   ---  -------------------  --------------------------------------------
// input     in   in_valid/in_ready    value[15:0]
// result    out  out_valid/out_ready  digit_enable, segments_lit, dwell_ticks,
//                                     hold, last
// config    in   APB write/read       dwell_base at byte 0
//
// One result beat per cycle unless out_ready stalls it; a value takes one beat
// per shown digit (1 to 4), from the back sequencer that peels one decimal digit
// (a divide by ten via reciprocal multiply) per beat. Input stage, queue and
// output register lie between input beat and first result beat. The front keeps
// taking values while the back stalls, until the queue fills. Reset is
// asynchronous, active low, and restores dwell_base to 50 with all pipelines empty.

module multiplexed_seven_segment_driver import mssd_pkg::*; #(
	parameter int QDEPTH = QDEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [VALUE_W-1:0] value,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [POS_N-1:0]        digit_enable,
	output logic [SEG_W-1:0]        segments_lit,
	output logic [DWELL_W-1:0]      dwell_ticks,
	output logic                    hold,
	output logic                    last,
	// APB config port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [CFG_AW-1:0]  paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	logic [DWELL_W-1:0] dwell_base_q;
	logic               cfg_wr;

	// front -> queue -> back
	logic  f_valid, f_ready;
	item_t f_item;
	logic  b_valid, b_ready;
	item_t b_item;

	// register file: one register, word index from paddr[2]
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_base_q <= DWELL_RESET;
		end else if (cfg_wr && paddr[2] == REG_DWELL_BASE) begin
			dwell_base_q <= pwdata[DWELL_W-1:0];
		end
	end

	// addresses beyond the register read as zero
	always_comb begin
		if (paddr[2] == REG_DWELL_BASE) begin
			prdata = {{(32-DWELL_W){1'b0}}, dwell_base_q};
		end else begin
			prdata = '0;
		end
	end

	mssd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item)
	);

	mssd_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_item  (f_item),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_item  (b_item)
	);

	mssd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.dwell_base   (dwell_base_q),
		.pop_valid    (b_valid),
		.pop_ready    (b_ready),
		.pop_item     (b_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.digit_enable (digit_enable),
		.segments_lit (segments_lit),
		.dwell_ticks  (dwell_ticks),
		.hold         (hold),
		.last         (last)
	);

	// a shown digit always selects exactly one position
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot(digit_enable))
		else $error("digit_enable not one-hot");

	// a held digit is the only, units digit, with no dwell
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hold) |-> (last && digit_enable == 4'b0001 && dwell_ticks == '0))
		else $error("hold beat malformed");

	// a non-final beat taken is followed by the next position up
	a_next_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=>
		(out_valid && digit_enable == ($past(digit_enable) << 1)))
		else $error("digit sequence broken");

endmodule

`default_nettype wire
